### hw/rtl/wggc_pkg.sv
// Package for the weighted greedy graph coloring block: payload types,
// opcodes, register map and the run sequencer's state type. No dependencies.
package wggc_pkg;

    typedef enum logic [1:0] {
        OP_LOAD_WEIGHT = 2'd0,
        OP_LOAD_ROW    = 2'd1,
        OP_RUN         = 2'd2,
        OP_NONE        = 2'd3
    } op_t;

    localparam logic [0:0] REG_TASK_COUNT = 1'b0;

    typedef struct packed {
        logic [1:0]  operation;
        logic [5:0]  task_index;
        logic [15:0] weight;
        logic [63:0] conflict_row;
    } in_word_t;

    typedef struct packed {
        logic [5:0]  machine_index;
        logic [21:0] machine_load;
        logic [63:0] task_set;
        logic [6:0]  machines_used;
        logic        last;
    } out_word_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT,
        ST_SORT_RD_I,
        ST_SORT_WT_I,
        ST_SORT_HOLD_I,
        ST_SORT_RD_J,
        ST_SORT_WT_J,
        ST_SORT_CMP,
        ST_SORT_PUT,
        ST_COL_RD,
        ST_COL_TASK,
        ST_COL_ROW,
        ST_COL_SCAN,
        ST_COL_PICK,
        ST_OUT_SCAN,
        ST_OUT_SEND
    } state_t;

endpackage

### hw/rtl/wggc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module wggc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

### hw/rtl/weighted_greedy_graph_coloring.sv
// Run order (N = clamped task count): loads are accepted back to back. A run
// accepts the request, fills the order table, sorts it by descending weight
// with memory-bound compares, colors each task (a serial scan of all N tasks'
// colors per task), then scans all tasks for each result word, which may
// stall on m_ready. One item at a time: the next item is accepted once
// the last word of a run sits in the output register.
// Reset (aresetn, synchronous) clears control state and sets task_count to
// MAX_NODES. Weight and conflict memories hold no reset value.
module weighted_greedy_graph_coloring #(
    parameter int MAX_NODES   = 64,
    parameter int WEIGHT_BITS = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  wggc_pkg::in_word_t   s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output wggc_pkg::out_word_t  m_data,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);
    import wggc_pkg::*;

    localparam int IW = $clog2(MAX_NODES);
    localparam int CW = IW + 1;

    state_t state_reg, state_next;
    logic [6:0]    task_count_reg;
    logic [CW-1:0] n_reg;
    logic [CW-1:0] i_reg, j_reg;
    logic [IW-1:0] oi_reg;         // task held at sort position i
    logic [IW-1:0] oj_reg;         // task read at sort position j
    logic [15:0]   wi_reg;         // weight of oi_reg
    logic [MAX_NODES-1:0] colored_reg, row_reg, used_reg, set_reg;
    logic [IW-1:0] task_reg;
    logic [IW-1:0] hc_reg, c_reg;
    logic [21:0]   load_reg;
    out_word_t     out_reg;
    logic          out_valid_reg;
    logic          scan_hit_q;
    logic [IW-1:0] scan_pos_q;
    logic [IW-1:0] scan_idx;
    logic [IW-1:0] free_c;

    // Config register
    assign pready = 1'b1;
    assign prdata = {25'd0, task_count_reg};
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            task_count_reg <= 7'(MAX_NODES);
        end else if (psel && penable && pwrite && paddr[2] == REG_TASK_COUNT) begin
            task_count_reg <= pwdata[6:0];
        end
    end

    // Memories
    logic          w_we, r_we, o_we, c_we;
    logic [IW-1:0] w_wa, w_ra, r_wa, r_ra, o_wa, o_ra, c_wa, c_ra;
    logic [15:0]   w_wd, w_rd;
    logic [MAX_NODES-1:0] r_wd, r_rd;
    logic [IW-1:0] o_wd, o_rd, c_wd, c_rd;

    wggc_ram #(.WIDTH(16), .DEPTH(MAX_NODES)) u_weight (.aclk, .we(w_we),
        .waddr(w_wa), .wdata(w_wd), .raddr(w_ra), .rdata(w_rd));
    wggc_ram #(.WIDTH(MAX_NODES), .DEPTH(MAX_NODES)) u_row (.aclk, .we(r_we),
        .waddr(r_wa), .wdata(r_wd), .raddr(r_ra), .rdata(r_rd));
    wggc_ram #(.WIDTH(IW), .DEPTH(MAX_NODES)) u_order (.aclk, .we(o_we),
        .waddr(o_wa), .wdata(o_wd), .raddr(o_ra), .rdata(o_rd));
    wggc_ram #(.WIDTH(IW), .DEPTH(MAX_NODES)) u_color (.aclk, .we(c_we),
        .waddr(c_wa), .wdata(c_wd), .raddr(c_ra), .rdata(c_rd));

    logic s_fire, m_fire, idx_ok, run_start, out_load;
    assign s_ready   = (state_reg == ST_IDLE);
    assign s_fire    = s_valid && s_ready;
    assign m_fire    = m_valid && m_ready;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_reg;
    assign idx_ok    = ({1'b0, s_data.task_index} < 7'(MAX_NODES));
    assign run_start = s_fire && s_data.operation == OP_RUN;
    assign out_load  = (state_reg == ST_OUT_SEND) && (!out_valid_reg || m_ready);
    assign scan_idx  = j_reg[IW-1:0];

    logic [15:0] wmask;
    assign wmask = (WEIGHT_BITS >= 16) ? 16'hFFFF : 16'((17'd1 << WEIGHT_BITS) - 17'd1);

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:        if (run_start) state_next = ST_INIT;
            ST_INIT: begin
                if (i_reg + 1'b1 == n_reg) begin
                    state_next = (n_reg == CW'(1)) ? ST_COL_RD : ST_SORT_RD_I;
                end
            end
            ST_SORT_RD_I:   state_next = ST_SORT_WT_I;
            ST_SORT_WT_I:   state_next = ST_SORT_HOLD_I;
            ST_SORT_HOLD_I: state_next = ST_SORT_RD_J;
            ST_SORT_RD_J:   state_next = ST_SORT_WT_J;
            ST_SORT_WT_J:   state_next = ST_SORT_CMP;
            ST_SORT_CMP: begin
                state_next = (j_reg + 1'b1 == n_reg) ? ST_SORT_PUT : ST_SORT_RD_J;
            end
            ST_SORT_PUT: begin
                state_next = (i_reg + CW'(2) >= n_reg) ? ST_COL_RD : ST_SORT_RD_I;
            end
            ST_COL_RD:      state_next = ST_COL_TASK;
            ST_COL_TASK:    state_next = ST_COL_ROW;
            ST_COL_ROW:     state_next = ST_COL_SCAN;
            ST_COL_SCAN:    if (j_reg == n_reg) state_next = ST_COL_PICK;
            ST_COL_PICK: begin
                state_next = (i_reg + 1'b1 == n_reg) ? ST_OUT_SCAN : ST_COL_RD;
            end
            ST_OUT_SCAN:    if (j_reg == n_reg) state_next = ST_OUT_SEND;
            ST_OUT_SEND: begin
                if (out_load) begin
                    state_next = (c_reg == hc_reg) ? ST_IDLE : ST_OUT_SCAN;
                end
            end
            default:        state_next = ST_IDLE;
        endcase
    end

    // Memory ports
    always_comb begin
        w_we = 1'b0; w_wa = s_data.task_index[IW-1:0]; w_wd = s_data.weight & wmask;
        r_we = 1'b0; r_wa = s_data.task_index[IW-1:0];
        r_wd = s_data.conflict_row[MAX_NODES-1:0];
        o_we = 1'b0; o_wa = i_reg[IW-1:0]; o_wd = i_reg[IW-1:0];
        c_we = 1'b0; c_wa = task_reg; c_wd = free_c;
        w_ra = scan_idx; r_ra = o_rd; o_ra = i_reg[IW-1:0]; c_ra = scan_idx;
        case (state_reg)
            ST_IDLE: begin
                w_we = s_fire && s_data.operation == OP_LOAD_WEIGHT && idx_ok;
                r_we = s_fire && s_data.operation == OP_LOAD_ROW && idx_ok;
            end
            ST_INIT:      o_we = 1'b1;
            ST_SORT_RD_I: o_ra = i_reg[IW-1:0];
            ST_SORT_WT_I: w_ra = o_rd;
            ST_SORT_RD_J: o_ra = j_reg[IW-1:0];
            ST_SORT_WT_J: w_ra = o_rd;
            ST_SORT_CMP: begin
                // heavier task at j moves up; old holder of i goes to j
                if (wi_reg < w_rd) begin
                    o_we = 1'b1; o_wa = j_reg[IW-1:0]; o_wd = oi_reg;
                end
            end
            ST_SORT_PUT: begin
                o_we = 1'b1; o_wa = i_reg[IW-1:0]; o_wd = oi_reg;
            end
            ST_COL_RD:    o_ra = i_reg[IW-1:0];
            ST_COL_TASK:  r_ra = o_rd;
            ST_COL_PICK:  c_we = 1'b1;
            default: ;
        endcase
    end

    // Lowest free color
    always_comb begin
        free_c = '0;
        for (int k = MAX_NODES - 1; k >= 0; k--) begin
            if (!used_reg[k]) free_c = IW'(k);
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            scan_hit_q    <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (out_load) out_valid_reg <= 1'b1;
            else if (m_fire) out_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE: begin
                    if (run_start) begin
                        n_reg <= (task_count_reg == 7'd0) ? CW'(1) :
                                 (task_count_reg > 7'(MAX_NODES)) ? CW'(MAX_NODES) :
                                 CW'(task_count_reg);
                        i_reg       <= '0;
                        colored_reg <= '0;
                        hc_reg      <= '0;
                    end
                end
                ST_INIT: begin
                    if (i_reg + 1'b1 == n_reg) i_reg <= '0;
                    else i_reg <= i_reg + 1'b1;
                end
                ST_SORT_WT_I: oi_reg <= o_rd;
                ST_SORT_HOLD_I: begin
                    wi_reg <= w_rd;
                    j_reg  <= i_reg + 1'b1;
                end
                ST_SORT_WT_J: oj_reg <= o_rd;
                ST_SORT_CMP: begin
                    if (wi_reg < w_rd) begin
                        oi_reg <= oj_reg;
                        wi_reg <= w_rd;
                    end
                    if (j_reg + 1'b1 != n_reg) j_reg <= j_reg + 1'b1;
                end
                ST_SORT_PUT: begin
                    if (i_reg + CW'(2) >= n_reg) i_reg <= '0;
                    else i_reg <= i_reg + 1'b1;
                end
                ST_COL_TASK: task_reg <= o_rd;
                ST_COL_ROW: begin
                    row_reg    <= r_rd;
                    j_reg      <= '0;
                    used_reg   <= '0;
                    scan_hit_q <= 1'b0;
                end
                ST_COL_SCAN: begin
                    // color read lands in the cycle after its address
                    if (scan_hit_q) used_reg[c_rd] <= 1'b1;
                    scan_hit_q <= (j_reg < n_reg) && row_reg[scan_idx] && colored_reg[scan_idx];
                    if (j_reg < n_reg) j_reg <= j_reg + 1'b1;
                end
                ST_COL_PICK: begin
                    colored_reg[task_reg] <= 1'b1;
                    if (free_c > hc_reg) hc_reg <= free_c;
                    if (i_reg + 1'b1 == n_reg) begin
                        i_reg <= '0; c_reg <= '0; j_reg <= '0;
                        load_reg <= '0; set_reg <= '0; scan_hit_q <= 1'b0;
                    end else begin
                        i_reg <= i_reg + 1'b1;
                    end
                end
                ST_OUT_SCAN: begin
                    scan_hit_q <= (j_reg < n_reg);
                    scan_pos_q <= scan_idx;
                    if (scan_hit_q && c_rd == c_reg) begin
                        load_reg <= load_reg + 22'(w_rd);
                        set_reg[scan_pos_q] <= 1'b1;
                    end
                    if (j_reg < n_reg) j_reg <= j_reg + 1'b1;
                end
                ST_OUT_SEND: begin
                    if (out_load) begin
                        out_reg.machine_index <= 6'(c_reg);
                        out_reg.machine_load  <= load_reg;
                        out_reg.task_set      <= 64'(set_reg);
                        out_reg.machines_used <= 7'(hc_reg) + 7'd1;
                        out_reg.last          <= (c_reg == hc_reg);
                        if (c_reg != hc_reg) c_reg <= c_reg + 1'b1;
                        j_reg <= '0; load_reg <= '0; set_reg <= '0;
                        scan_hit_q <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("held result changed");
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> state_reg == ST_IDLE)
        else $error("ready outside idle");
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_COL_PICK |-> !used_reg[free_c])
        else $error("picked used color");
endmodule
